>>> hdl/lfs_pkg.sv
// Shared types, constants and CRC helper for the lidar frame parser.
// Depends on nothing; lfs_crc_unit, lfs_frame_ctrl and the top import it.
package lfs_pkg;

  localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [7:0]  HEAD_B0   = 8'h44;
  localparam logic [7:0]  HEAD_B1   = 8'h45;
  localparam logic [7:0]  HEAD_B2   = 8'h32;
  localparam logic [7:0]  HEAD_B3   = 8'h30;
  localparam logic [31:0] HEAD_WORD = {HEAD_B3, HEAD_B2, HEAD_B1, HEAD_B0};
  localparam logic [23:0] HEAD_WIN  = {HEAD_B0, HEAD_B1, HEAD_B2};

  localparam int FRAME_LEN  = 24;
  localparam int CRC_WORDS  = 5;
  localparam int IDX_W      = 5;
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_DIST  = IDX_W'(11);
  localparam logic [IDX_W-1:0] IDX_AMP   = IDX_W'(15);
  localparam logic [IDX_W-1:0] IDX_CRC_END = IDX_W'(4 * CRC_WORDS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);

  // Bytes per word, which is also the number of CRC steps per word.
  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] WORD_STEPS = CNT_W'(4);

  typedef enum logic {
    ST_HUNT,
    ST_CAPTURE
  } lfs_state_t;

  // Commands from the frame controller to the CRC unit.
  typedef struct packed {
    logic        start;  // header found: restart with the header word
    logic        load;   // a frame word within bytes 0 to 19 is complete
    logic [31:0] word;
  } lfs_crc_ctl_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] amplitude;
    logic        crc_ok;
  } lfs_result_t;

  // Eight bits of the CRC, most significant data bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in;
    for (int k = 7; k >= 0; k--) begin
      if (c[31] ^ data[k]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/lfs_if.sv
// Valid/ready channel interfaces for the byte input and the frame result.
// Depends on nothing.
interface lfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic [31:0] amplitude;
  logic        crc_ok;

  modport source (output valid, output distance, output amplitude, output crc_ok,
                  input ready);
  modport sink (input valid, input distance, input amplitude, input crc_ok,
                output ready);
endinterface

>>> hdl/lfs_crc_unit.sv
// Byte-serial CRC-32 engine: folds each completed word in, top byte first.
// Depends on lfs_pkg.
module lfs_crc_unit
  import lfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lfs_crc_ctl_t ctl,
  output logic [31:0]  crc_now
);

  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy;
  logic [31:0]      crc_step;

  assign busy     = (cnt_r != '0);
  assign crc_step = busy ? crc_byte(crc_r, word_r[31:24]) : crc_r;
  // CRC as it stands after this edge; a frame end uses it for the compare.
  assign crc_now  = crc_step;

  always_comb begin
    crc_nxt  = crc_step;
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    if (ctl.start) begin
      crc_nxt  = CRC_INIT;
      word_nxt = HEAD_WORD;
      cnt_nxt  = WORD_STEPS;
    end else if (ctl.load) begin
      word_nxt = ctl.word;
      cnt_nxt  = WORD_STEPS;
    end else if (busy) begin
      word_nxt = {word_r[23:0], 8'h00};
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    crc_r  <= crc_nxt;
    word_r <= word_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= WORD_STEPS)
    else $error("CRC step count out of range");

  // A new word may only arrive in the previous word's last step or later.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.start || ctl.load) |-> (cnt_r <= CNT_W'(1)))
    else $error("CRC word arrived before the previous word was folded in");

endmodule

>>> hdl/lfs_frame_ctrl.sv
// Header hunt, frame byte capture and word assembly for the lidar parser.
// Depends on lfs_pkg.
module lfs_frame_ctrl
  import lfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   rx_byte,
  input  logic [31:0]  crc_now,
  output lfs_crc_ctl_t crc_ctl,
  output logic         fire,
  output lfs_result_t  result
);

  lfs_state_t       state_r, state_nxt;
  logic [23:0]      win_r, win_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      asm_r, asm_val;
  logic [31:0]      dist_r, dist_nxt;
  logic [31:0]      amp_r, amp_nxt;
  logic             head_hit, word_done, last;

  assign head_hit  = (win_r == HEAD_WIN) && (rx_byte == HEAD_B3);
  assign word_done = (idx_r[1:0] == 2'd3);
  assign last      = (idx_r >= IDX_LAST);

  // Place the byte into its little-endian lane; lane zero starts a new word.
  always_comb begin
    case (idx_r[1:0])
      2'd0:    asm_val = {24'h0, rx_byte};
      2'd1:    asm_val = {asm_r[31:16], rx_byte, asm_r[7:0]};
      2'd2:    asm_val = {asm_r[31:24], rx_byte, asm_r[15:0]};
      default: asm_val = {rx_byte, asm_r[23:0]};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_HUNT: begin
        if (accept && head_hit) state_nxt = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        if (accept && last) state_nxt = ST_HUNT;
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_comb begin
    win_nxt       = win_r;
    idx_nxt       = idx_r;
    dist_nxt      = dist_r;
    amp_nxt       = amp_r;
    crc_ctl.start = 1'b0;
    crc_ctl.load  = 1'b0;
    crc_ctl.word  = asm_val;
    fire          = 1'b0;
    unique case (state_r)
      ST_HUNT: begin
        if (accept) begin
          if (head_hit) begin
            win_nxt       = '0;
            idx_nxt       = IDX_FIRST;
            crc_ctl.start = 1'b1;
          end else begin
            win_nxt = {win_r[15:0], rx_byte};
          end
        end
      end
      ST_CAPTURE: begin
        if (accept) begin
          crc_ctl.load = word_done && (idx_r < IDX_CRC_END);
          if (idx_r == IDX_DIST) dist_nxt = asm_val;
          if (idx_r == IDX_AMP)  amp_nxt  = asm_val;
          if (last) begin
            fire    = 1'b1;
            idx_nxt = '0;
            win_nxt = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign result.distance  = dist_r;
  assign result.amplitude = amp_r;
  assign result.crc_ok    = (crc_now == asm_val);

  always_ff @(posedge clk) begin
    if (accept) asm_r <= asm_val;
    dist_r <= dist_nxt;
    amp_r  <= amp_nxt;
    if (!rst_n) begin
      state_r <= ST_HUNT;
      win_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_hunt_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HUNT) |-> (idx_r == '0))
    else $error("Byte index not cleared while hunting");

  a_capture_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CAPTURE) |-> ((idx_r >= IDX_FIRST) && (idx_r <= IDX_LAST) &&
                                 (win_r == '0)))
    else $error("Capture state with bad index or stale header window");

endmodule

>>> hdl/lidar_frame_sync_crc32_parser.sv
// Top level of the lidar frame parser: handshake, result register, subunits.
// Depends on lfs_pkg, lfs_if, lfs_crc_unit and lfs_frame_ctrl.
//
// Usage: bytes from the sensor serial link enter on in_chan, one byte per
// transaction. The block hunts for the header 44 45 32 30, then captures a
// 24-byte frame that starts with the header. Frame bytes 0 to 19 run through
// a CRC-32 (poly 04C11DB7, init all ones, no reflection, no final xor) as
// five little-endian words, and the result is compared with bytes 20 to 23.
// On the last frame byte one transaction leaves on out_chan carrying the
// distance (bytes 8 to 11), the amplitude (bytes 12 to 15) and crc_ok.
// The result is registered, so it is valid in the cycle after the
// transaction that carries the last frame byte. Throughput: one byte per
// cycle while the output register can take a result. The CRC unit folds
// each completed word in one byte per clock, done by the next word's load.
// Reset (synchronous, active low) returns the block to hunting with an empty
// header window and no result pending. When the receiver stalls, the result
// waits in the output register; input is still taken each cycle unless that
// register is full and not being drained in the same cycle.
module lidar_frame_sync_crc32_parser
  import lfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lfs_in_if.sink    in_chan,
  lfs_out_if.source out_chan
);

  logic         accept;
  logic         fire;
  lfs_crc_ctl_t crc_ctl;
  lfs_result_t  result;
  logic [31:0]  crc_now;

  logic         out_valid_r, out_valid_nxt;
  lfs_result_t  out_data_r;

  // The output register can take a new result when empty or being drained.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  lfs_frame_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_chan.rx_byte),
    .crc_now (crc_now),
    .crc_ctl (crc_ctl),
    .fire    (fire),
    .result  (result)
  );

  lfs_crc_unit u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (crc_ctl),
    .crc_now (crc_now)
  );

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data_r <= result;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.distance  = out_data_r.distance;
  assign out_chan.amplitude = out_data_r.amplitude;
  assign out_chan.crc_ok    = out_data_r.crc_ok;

  // A pending result must never be overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (!out_valid_r || out_chan.ready))
    else $error("Result produced while the output register was held");

endmodule
